/* rtl/pfam_pkg.sv */
package pfam_pkg;

	localparam int FRAC = 32;
	localparam int W    = 48;
	localparam int IDX_W = 3;

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	localparam logic [IDX_W-1:0] REG_CUTOFF = 3'd0;
	localparam logic [IDX_W-1:0] REG_MINR   = 3'd1;
	localparam logic [IDX_W-1:0] REG_MASS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_SIZE   = 3'd4;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_req_t;

endpackage

/* rtl/pfam_alu.sv */
module pfam_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  pfam_pkg::alu_req_t  req,
	input  logic [63:0]         a,
	input  logic [63:0]         b,
	input  logic [127:0]        n,
	output logic [127:0]        res,
	output logic [63:0]         rem,
	output logic                done
);
	import pfam_pkg::*;

	logic         run_q;
	logic         done_q;
	logic [1:0]   op_q;
	logic [6:0]   cnt_q;
	logic [127:0] x_q;
	logic [63:0]  y_q;
	logic [127:0] acc_q;
	logic [65:0]  rem_q;

	logic [127:0] mul_acc;
	logic [63:0]  div_sh;
	logic         div_ge;
	logic [63:0]  div_rem;
	logic [67:0]  sq_r4;
	logic [67:0]  sq_trial;
	logic         sq_ge;
	logic [67:0]  sq_diff;

	always_comb begin
		mul_acc  = y_q[0] ? acc_q + x_q : acc_q;
		div_sh   = {rem_q[62:0], x_q[127]};
		div_ge   = rem_q[63] || (div_sh >= y_q);
		div_rem  = div_sh - y_q;
		sq_r4    = {rem_q, x_q[127:126]};
		sq_trial = {2'b00, acc_q[63:0], 2'b01};
		sq_ge    = sq_r4 >= sq_trial;
		sq_diff  = sq_r4 - sq_trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				op_q  <= req.op;
				cnt_q <= (req.op == OP_DIV) ? 7'd127 : 7'd63;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			rem_q <= '0;
			y_q   <= b;
			case (req.op)
				OP_MUL:  x_q <= {64'd0, a};
				default: x_q <= n;
			endcase
		end else if (run_q) begin
			case (op_q)
				OP_MUL: begin
					acc_q <= mul_acc;
					x_q   <= x_q << 1;
					y_q   <= y_q >> 1;
				end
				OP_DIV: begin
					x_q   <= x_q << 1;
					acc_q <= {acc_q[126:0], div_ge};
					rem_q <= {2'b00, div_ge ? div_rem : div_sh};
				end
				default: begin
					x_q   <= x_q << 2;
					acc_q <= {acc_q[126:0], sq_ge};
					rem_q <= sq_ge ? sq_diff[65:0] : sq_r4[65:0];
				end
			endcase
		end
	end

	assign res  = acc_q;
	assign rem  = rem_q[63:0];
	assign done = done_q;

endmodule

/* rtl/particle_force_accumulate_and_move.sv */
// Pair force accumulation and Euler move for one target particle at a time.
// Items arrive on item_valid/item_ready. A run for one target starts with an
// item that has first set (loads position and velocity, clears acceleration
// and the saturation flag), each has_neighbor item within the cutoff adds one
// pair force, and the item with last moves the particle, reflects it off the
// walls at 0 and domain_size and offers one word on result_valid/result_ready.
// All arithmetic runs through one iterative unit that does multiply, divide
// and square root. An item with a neighbor needs up to six multiplies, one
// root and seven divides; last adds four multiplies plus up to two divides
// for the wall folds; a plain item needs no arithmetic.
// item_ready is high only while the sequencer is idle. A finished word holds
// on the outputs until result_ready; no new item is taken meanwhile.
// The cfg channel is always ready; the user must write registers on it only
// while the block is idle, which the block does not enforce. Reset clears the
// held particle, acceleration and flag and loads the register defaults.
module particle_force_accumulate_and_move (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfam_pkg::IDX_W-1:0]      cfg_index,
	input  logic [pfam_pkg::W-1:0]          cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic signed [pfam_pkg::W-1:0]   particle_x,
	input  logic signed [pfam_pkg::W-1:0]   particle_y,
	input  logic signed [pfam_pkg::W-1:0]   particle_vx,
	input  logic signed [pfam_pkg::W-1:0]   particle_vy,
	input  logic signed [pfam_pkg::W-1:0]   neighbor_x,
	input  logic signed [pfam_pkg::W-1:0]   neighbor_y,
	input  logic                            first,
	input  logic                            has_neighbor,
	input  logic                            last,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic signed [pfam_pkg::W-1:0]   new_x,
	output logic signed [pfam_pkg::W-1:0]   new_y,
	output logic signed [pfam_pkg::W-1:0]   new_vx,
	output logic signed [pfam_pkg::W-1:0]   new_vy,
	output logic                            saturated
);
	import pfam_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DSQX = 5'd1;
	localparam logic [4:0] S_DSQY = 5'd2;
	localparam logic [4:0] S_CUT  = 5'd3;
	localparam logic [4:0] S_MIN  = 5'd4;
	localparam logic [4:0] S_SQRT = 5'd5;
	localparam logic [4:0] S_T    = 5'd6;
	localparam logic [4:0] S_UX   = 5'd7;
	localparam logic [4:0] S_VX   = 5'd8;
	localparam logic [4:0] S_WX   = 5'd9;
	localparam logic [4:0] S_AX   = 5'd10;
	localparam logic [4:0] S_UY   = 5'd11;
	localparam logic [4:0] S_VY   = 5'd12;
	localparam logic [4:0] S_WY   = 5'd13;
	localparam logic [4:0] S_AY   = 5'd14;
	localparam logic [4:0] S_MVX  = 5'd15;
	localparam logic [4:0] S_MPX  = 5'd16;
	localparam logic [4:0] S_FX   = 5'd17;
	localparam logic [4:0] S_MVY  = 5'd18;
	localparam logic [4:0] S_MPY  = 5'd19;
	localparam logic [4:0] S_FY   = 5'd20;
	localparam logic [4:0] S_OUT  = 5'd21;

	localparam logic [2:0] K_MUL  = 3'd0;
	localparam logic [2:0] K_SQRT = 3'd1;
	localparam logic [2:0] K_QMUL = 3'd2;
	localparam logic [2:0] K_QDIV = 3'd3;
	localparam logic [2:0] K_DIV  = 3'd4;

	localparam logic [63:0] TOP64  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_Q  = 64'd1 << FRAC;
	localparam logic [W-1:0] MAX48 = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN48 = {1'b1, {(W-1){1'b0}}};

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? 64'd0 - v : v;
	endfunction

	function automatic logic [63:0] sx64(input logic [W-1:0] v);
		sx64 = {{(64-W){v[W-1]}}, v};
	endfunction

	// {flag, value}
	function automatic logic [64:0] sadd(input logic [63:0] x, input logic [63:0] y);
		logic [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63])
			sadd = {1'b1, s[64] ? TOP64 : MAX64};
		else
			sadd = {1'b0, s[63:0]};
	endfunction

	function automatic logic [W:0] sat48(input logic [63:0] v);
		if (v[63:W-1] == '0 || v[63:W-1] == '1)
			sat48 = {1'b0, v[W-1:0]};
		else
			sat48 = {1'b1, v[63] ? MIN48 : MAX48};
	endfunction

	logic [W-1:0]   cutoff_q, minr_q, mass_q, dt_q;
	logic [W-2:0]   size_q;

	logic [4:0]     state_q;
	logic           issued_q;
	logic           last_q;
	logic signed [W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic [63:0]    acc_x_q, acc_y_q;
	logic           sat_seen_q;
	logic [W:0]     dx_q, dy_q;
	logic [97:0]    r2_q;
	logic [63:0]    r_q, t_q, tmp_q;

	logic [2:0]     kind;
	logic [63:0]    sa, sb, ua, ub;
	logic [127:0]   un;
	alu_req_t       req;
	logic [63:0]    alu_a, alu_b;
	logic [127:0]   alu_n, alu_res;
	logic [63:0]    alu_rem;
	logic           alu_done;

	logic           neg, div_zero, over, qsat, fin;
	logic [127:0]   m;
	logic [63:0]    mq, qres;
	logic [63:0]    add_a;
	logic [64:0]    add_r;
	logic [W:0]     c48;
	logic [W:0]     dmag;
	logic [97:0]    r2n;

	logic signed [W-1:0] fx, fv;
	logic [W-1:0]   fa;
	logic           in_range, flip;
	logic [W-2:0]   mp1, newp;
	logic           fold_skip;

	always_comb begin
		kind = K_QDIV;
		sa   = '0;
		sb   = '0;
		ua   = '0;
		ub   = '0;
		un   = '0;
		dmag = (state_q == S_DSQX) ? (dx_q[W] ? '0 - dx_q : dx_q)
		                           : (dy_q[W] ? '0 - dy_q : dy_q);
		fx   = (state_q == S_FX) ? pos_x_q : pos_y_q;
		fv   = (state_q == S_FX) ? vel_x_q : vel_y_q;
		fa   = fx[W-1] ? '0 - fx : fx;
		case (state_q)
			S_DSQX, S_DSQY: begin
				kind = K_MUL;
				ua   = {{(63-W){1'b0}}, dmag};
				ub   = {{(63-W){1'b0}}, dmag};
			end
			S_CUT: begin
				kind = K_MUL;
				ua   = {{(64-W){1'b0}}, cutoff_q};
				ub   = {{(64-W){1'b0}}, cutoff_q};
			end
			S_MIN: begin
				kind = K_MUL;
				ua   = {{(64-W){1'b0}}, minr_q};
				ub   = {{(64-W){1'b0}}, minr_q};
			end
			S_SQRT: begin
				kind = K_SQRT;
				un   = {30'd0, r2_q};
			end
			S_T: begin
				sa = {{(64-W){1'b0}}, cutoff_q};
				sb = r_q;
			end
			S_UX: begin
				sa = {{(63-W){dx_q[W]}}, dx_q};
				sb = r_q;
			end
			S_UY: begin
				sa = {{(63-W){dy_q[W]}}, dy_q};
				sb = r_q;
			end
			S_VX, S_VY: begin
				sa = tmp_q;
				sb = r_q;
			end
			S_WX, S_WY: begin
				kind = K_QMUL;
				sa   = tmp_q;
				sb   = t_q;
			end
			S_AX, S_AY: begin
				sa = tmp_q;
				sb = {{(64-W){1'b0}}, mass_q};
			end
			S_MVX: begin
				kind = K_QMUL;
				sa   = acc_x_q;
				sb   = {{(64-W){1'b0}}, dt_q};
			end
			S_MVY: begin
				kind = K_QMUL;
				sa   = acc_y_q;
				sb   = {{(64-W){1'b0}}, dt_q};
			end
			S_MPX: begin
				kind = K_QMUL;
				sa   = sx64(vel_x_q);
				sb   = {{(64-W){1'b0}}, dt_q};
			end
			S_MPY: begin
				kind = K_QMUL;
				sa   = sx64(vel_y_q);
				sb   = {{(64-W){1'b0}}, dt_q};
			end
			S_FX, S_FY: begin
				kind = K_DIV;
				un   = {{(128-W){1'b0}}, fa - {{(W-1){1'b0}}, 1'b1}};
				ub   = {{(65-W){1'b0}}, size_q};
			end
			default: begin
				kind = K_QDIV;
			end
		endcase
	end

	always_comb begin
		neg      = sa[63] ^ sb[63];
		div_zero = (kind == K_QDIV) && (sb == '0);
		alu_a    = (kind == K_QMUL) ? mag64(sa) : ua;
		alu_b    = (kind == K_QMUL || kind == K_QDIV) ? mag64(sb) : ub;
		alu_n    = (kind == K_QDIV) ? ({64'd0, mag64(sa)} << FRAC) : un;
		case (kind)
			K_MUL, K_QMUL: req.op = OP_MUL;
			K_SQRT:        req.op = OP_SQRT;
			default:       req.op = OP_DIV;
		endcase

		m    = (kind == K_QMUL) ? (alu_res >> FRAC) : alu_res;
		over = (m[127:64] != '0) || (m[63:0] > (neg ? TOP64 : MAX64));
		mq   = over ? (neg ? TOP64 : MAX64) : m[63:0];
		qres = neg ? 64'd0 - mq : mq;
		qsat = over;
		if (div_zero) begin
			qsat = 1'b1;
			if (sa == '0)
				qres = '0;
			else
				qres = sa[63] ? TOP64 : MAX64;
		end

		case (state_q)
			S_AX:    add_a = acc_x_q;
			S_AY:    add_a = acc_y_q;
			S_MVX:   add_a = sx64(vel_x_q);
			S_MVY:   add_a = sx64(vel_y_q);
			S_MPX:   add_a = sx64(pos_x_q);
			default: add_a = sx64(pos_y_q);
		endcase
		add_r = sadd(add_a, qres);
		c48   = sat48(add_r[63:0]);

		r2n = (alu_res[97:0] > r2_q) ? alu_res[97:0] : r2_q;

		in_range  = !fx[W-1] && (fx[W-2:0] <= size_q);
		fold_skip = (size_q == '0) || in_range;
		mp1       = alu_rem[W-2:0] + {{(W-2){1'b0}}, 1'b1};
		newp      = alu_res[0] ? size_q - mp1 : mp1;
		flip      = fx[W-1] ? ~alu_res[0] : alu_res[0];

		fin = issued_q ? alu_done : div_zero;
		req.start = !issued_q && !div_zero && (state_q != S_IDLE) && (state_q != S_OUT)
		            && !(((state_q == S_FX) || (state_q == S_FY)) && fold_skip);
	end

	pfam_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (alu_a),
		.b      (alu_b),
		.n      (alu_n),
		.res    (alu_res),
		.rem    (alu_rem),
		.done   (alu_done)
	);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= 48'd42949673;
			minr_q   <= 48'd429497;
			mass_q   <= 48'd42949673;
			dt_q     <= 48'd2147484;
			size_q   <= 47'd4294967296;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CUTOFF: cutoff_q <= cfg_data;
				REG_MINR:   minr_q   <= cfg_data;
				REG_MASS:   mass_q   <= cfg_data;
				REG_DT:     dt_q     <= cfg_data;
				REG_SIZE:   size_q   <= cfg_data[W-2:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issued_q   <= 1'b0;
			last_q     <= 1'b0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			vel_x_q    <= '0;
			vel_y_q    <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			sat_seen_q <= 1'b0;
		end else begin
			if (req.start)
				issued_q <= 1'b1;
			if (fin)
				issued_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						last_q <= last;
						if (first) begin
							pos_x_q    <= particle_x;
							pos_y_q    <= particle_y;
							vel_x_q    <= particle_vx;
							vel_y_q    <= particle_vy;
							acc_x_q    <= '0;
							acc_y_q    <= '0;
							sat_seen_q <= 1'b0;
						end
						if (has_neighbor)
							state_q <= S_DSQX;
						else if (last)
							state_q <= S_MVX;
					end
				end
				S_DSQX: if (fin) begin
					state_q <= S_DSQY;
				end
				S_DSQY: if (fin) begin
					state_q <= S_CUT;
				end
				S_CUT: if (fin) begin
					if (alu_res[97:0] < r2_q)
						state_q <= last_q ? S_MVX : S_IDLE;
					else
						state_q <= S_MIN;
				end
				S_MIN: if (fin) begin
					if (r2n == '0)
						state_q <= last_q ? S_MVX : S_IDLE;
					else
						state_q <= S_SQRT;
				end
				S_SQRT: if (fin) begin
					state_q <= S_T;
				end
				S_T:  if (fin) state_q <= S_UX;
				S_UX: if (fin) state_q <= S_VX;
				S_VX: if (fin) state_q <= S_WX;
				S_WX: if (fin) state_q <= S_AX;
				S_AX: if (fin) state_q <= S_UY;
				S_UY: if (fin) state_q <= S_VY;
				S_VY: if (fin) state_q <= S_WY;
				S_WY: if (fin) state_q <= S_AY;
				S_AY: if (fin) state_q <= last_q ? S_MVX : S_IDLE;
				S_MVX: if (fin) begin
					vel_x_q    <= c48[W-1:0];
					sat_seen_q <= sat_seen_q | qsat | add_r[64] | c48[W];
					state_q    <= S_MPX;
				end
				S_MPX: if (fin) begin
					pos_x_q    <= c48[W-1:0];
					sat_seen_q <= sat_seen_q | qsat | add_r[64] | c48[W];
					state_q    <= S_FX;
				end
				S_MVY: if (fin) begin
					vel_y_q    <= c48[W-1:0];
					sat_seen_q <= sat_seen_q | qsat | add_r[64] | c48[W];
					state_q    <= S_MPY;
				end
				S_MPY: if (fin) begin
					pos_y_q    <= c48[W-1:0];
					sat_seen_q <= sat_seen_q | qsat | add_r[64] | c48[W];
					state_q    <= S_FY;
				end
				S_FX, S_FY: begin
					if (!issued_q && fold_skip) begin
						if (size_q == '0) begin
							if (state_q == S_FX)
								pos_x_q <= '0;
							else
								pos_y_q <= '0;
						end
						state_q <= (state_q == S_FX) ? S_MVY : S_OUT;
					end else if (issued_q && alu_done) begin
						if (state_q == S_FX) begin
							pos_x_q <= {1'b0, newp};
							if (flip)
								vel_x_q <= (fv == MIN48) ? MAX48 : '0 - fv;
						end else begin
							pos_y_q <= {1'b0, newp};
							if (flip)
								vel_y_q <= (fv == MIN48) ? MAX48 : '0 - fv;
						end
						if (flip && fv == MIN48)
							sat_seen_q <= 1'b1;
						state_q <= (state_q == S_FX) ? S_MVY : S_OUT;
					end
				end
				S_OUT: begin
					if (result_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (fin && (state_q == S_T || state_q == S_UX || state_q == S_VX
			    || state_q == S_WX || state_q == S_UY || state_q == S_VY
			    || state_q == S_WY))
				sat_seen_q <= sat_seen_q | qsat;
			if (fin && state_q == S_AX) begin
				acc_x_q    <= add_r[63:0];
				sat_seen_q <= sat_seen_q | qsat | add_r[64];
			end
			if (fin && state_q == S_AY) begin
				acc_y_q    <= add_r[63:0];
				sat_seen_q <= sat_seen_q | qsat | add_r[64];
			end
		end
	end

	// datapath temporaries
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			dx_q <= {neighbor_x[W-1], neighbor_x}
			        - (first ? {particle_x[W-1], particle_x} : {pos_x_q[W-1], pos_x_q});
			dy_q <= {neighbor_y[W-1], neighbor_y}
			        - (first ? {particle_y[W-1], particle_y} : {pos_y_q[W-1], pos_y_q});
		end
		if (fin) begin
			case (state_q)
				S_DSQX: r2_q <= alu_res[97:0];
				S_DSQY: r2_q <= r2_q + alu_res[97:0];
				S_MIN:  r2_q <= r2n;
				S_SQRT: r_q  <= alu_res[63:0];
				S_T:    t_q  <= ONE_Q - qres;
				S_UX, S_VX, S_WX, S_UY, S_VY, S_WY: tmp_q <= qres;
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = (state_q == S_OUT);
	assign new_x        = pos_x_q;
	assign new_y        = pos_y_q;
	assign new_vx       = vel_x_q;
	assign new_vy       = vel_y_q;
	assign saturated    = sat_seen_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import pfam_pkg::*;

	localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint MIN48 = -64'sh0000_8000_0000_0000;
	localparam longint MAXI64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint MINI64 = 64'sh8000_0000_0000_0000;
	localparam int SETTLE = 4000;
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		logic [W-1:0] px, py, pvx, pvy, nx, ny;
		logic f, h, l;
	} particle_item_t;

	typedef struct {
		logic [W-1:0] x, y, vx, vy;
		logic sat;
	} moved_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid, cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [W-1:0] cfg_data;
	logic item_valid, item_ready;
	logic signed [W-1:0] particle_x, particle_y, particle_vx, particle_vy;
	logic signed [W-1:0] neighbor_x, neighbor_y;
	logic first, has_neighbor, last;
	logic result_valid, result_ready;
	logic signed [W-1:0] new_x, new_y, new_vx, new_vy;
	logic saturated;

	particle_item_t pending_items[$];
	moved_t expected_moves[$];
	int mismatches = 0;
	int moves_seen = 0;
	int tx_wait, rx_wait, squeeze_left, idle_cycles;
	bit calm_tx, calm_rx, squeeze_done;

	// predictor copy of registers and particle state
	logic [63:0] cutoff_r, min_r, mass_r, dt_r, size_r;
	longint held_px, held_py, held_vx, held_vy, acc_x, acc_y;
	bit sat_seen, step_sat;

	particle_force_accumulate_and_move dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint pack(bit neg, logic [127:0] m);
		logic [127:0] cap;
		cap = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
		if (m > cap) begin
			m = cap;
			step_sat = 1;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		p = {64'd0, mag(a)} * {64'd0, mag(b)};
		return pack((a < 0) != (b < 0), p >> FRAC);
	endfunction

	function automatic longint fx_div(longint a, longint b);
		logic [127:0] n;
		if (b == 0) begin
			step_sat = 1;
			return a == 0 ? 0 : (a < 0 ? MINI64 : MAXI64);
		end
		n = {64'd0, mag(a)} << FRAC;
		return pack((a < 0) != (b < 0), n / {64'd0, mag(b)});
	endfunction

	function automatic longint sat_add(longint a, longint b);
		logic signed [64:0] s;
		s = a;
		s = s + b;
		if (s > MAXI64) begin
			step_sat = 1;
			return MAXI64;
		end
		if (s < MINI64) begin
			step_sat = 1;
			return MINI64;
		end
		return longint'(s);
	endfunction

	function automatic longint clamp48(longint v);
		if (v > MAX48) begin
			step_sat = 1;
			return MAX48;
		end
		if (v < MIN48) begin
			step_sat = 1;
			return MIN48;
		end
		return v;
	endfunction

	function automatic logic [63:0] root_of(logic [127:0] v);
		logic [63:0] res, c;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= v) res = c;
		end
		return res;
	endfunction

	function automatic void add_pair_force(longint nx, longint ny);
		longint dx, dy, r, t, v;
		logic [127:0] r2, lim, low;
		dx = nx - held_px;
		dy = ny - held_py;
		r2 = {64'd0, mag(dx)} * {64'd0, mag(dx)} + {64'd0, mag(dy)} * {64'd0, mag(dy)};
		lim = {64'd0, cutoff_r} * {64'd0, cutoff_r};
		low = {64'd0, min_r} * {64'd0, min_r};
		if (r2 > lim) return;
		if (low > r2) r2 = low;
		if (r2 == 0) return;
		r = longint'(root_of(r2));
		t = (64'sd1 <<< FRAC) - fx_div(longint'(cutoff_r), r);
		v = fx_div(fx_div(dx, r), r);
		acc_x = sat_add(acc_x, fx_div(fx_mul(v, t), longint'(mass_r)));
		v = fx_div(fx_div(dy, r), r);
		acc_y = sat_add(acc_y, fx_div(fx_mul(v, t), longint'(mass_r)));
	endfunction

	function automatic void wall_fold(inout longint p, inout longint vel);
		logic [63:0] a, j, rem, flips;
		longint x;
		x = p;
		if (size_r == 0) begin
			p = 0;
			return;
		end
		if (x >= 0 && 64'(x) <= size_r) return;
		a = mag(x);
		j = (a + size_r - 1) / size_r;
		rem = a - (j - 1) * size_r;
		p = longint'(((j - 1) & 1) ? size_r - rem : rem);
		flips = x < 0 ? j : j - 1;
		if (flips[0]) begin
			if (vel == MIN48) begin
				vel = MAX48;
				step_sat = 1;
			end else
				vel = -vel;
		end
	endfunction

	function automatic void move_axis(inout longint p, inout longint vel, input longint acc);
		longint dt;
		dt = longint'(dt_r);
		vel = clamp48(sat_add(vel, fx_mul(acc, dt)));
		p = clamp48(sat_add(p, fx_mul(vel, dt)));
		wall_fold(p, vel);
	endfunction

	function automatic void predict_move(particle_item_t it);
		longint sx, sy;
		moved_t m;
		step_sat = 0;
		if (it.f) begin
			held_px = signed'(it.px);
			held_py = signed'(it.py);
			held_vx = signed'(it.pvx);
			held_vy = signed'(it.pvy);
			acc_x = 0;
			acc_y = 0;
			sat_seen = 0;
		end
		sx = signed'(it.nx);
		sy = signed'(it.ny);
		if (it.h) add_pair_force(sx, sy);
		if (step_sat) sat_seen = 1;
		if (!it.l) return;
		step_sat = 0;
		move_axis(held_px, held_vx, acc_x);
		move_axis(held_py, held_vy, acc_y);
		if (step_sat) sat_seen = 1;
		m.x = held_px[W-1:0];
		m.y = held_py[W-1:0];
		m.vx = held_vx[W-1:0];
		m.vy = held_vy[W-1:0];
		m.sat = sat_seen;
		expected_moves = {expected_moves, m};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [W-1:0] rand48();
		return W'(rand64());
	endfunction

	task automatic queue_item(logic [W-1:0] px, py, pvx, pvy, nx, ny, bit f, h, l);
		particle_item_t it;
		it = '{px, py, pvx, pvy, nx, ny, f, h, l};
		pending_items = {pending_items, it};
	endtask

	function automatic logic [W-1:0] near_pos(logic [W-1:0] base);
		longint off;
		off = longint'(rand64() % (4 * cutoff_r + 3)) - longint'(2 * cutoff_r + 1);
		return base + off[W-1:0];
	endfunction

	// one target run: first, a few neighbors, last; noise now and then
	task automatic queue_runs(int n);
		int made;
		logic [W-1:0] px, py, vx, vy;
		int len;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 6) == 0) begin
				queue_item(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
				made++;
				continue;
			end
			px = W'(rand64() % (size_r + 1));
			py = W'(rand64() % (size_r + 1));
			vx = W'((rand64() % 64'h4_0000_0000) - 64'h2_0000_0000);
			vy = W'((rand64() % 64'h4_0000_0000) - 64'h2_0000_0000);
			len = $urandom_range(0, 4);
			queue_item(px, py, vx, vy, near_pos(px), near_pos(py), 1,
				$urandom_range(0, 1), len == 0);
			made++;
			for (int i = 0; i < len; i++) begin
				queue_item(rand48(), rand48(), rand48(), rand48(), near_pos(px), near_pos(py),
					0, $urandom_range(0, 4) != 0, i == len - 1);
				made++;
			end
		end
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CUTOFF: cutoff_r = {16'd0, data};
			REG_MINR:   min_r = {16'd0, data};
			REG_MASS:   mass_r = {16'd0, data};
			REG_DT:     dt_r = {16'd0, data};
			REG_SIZE:   size_r = {17'd0, data[W-2:0]};
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_moves.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(logic [W-1:0] c, m, ms, dt, sz);
		write_reg(REG_CUTOFF, c);
		write_reg(REG_MINR, m);
		write_reg(REG_MASS, ms);
		write_reg(REG_DT, dt);
		write_reg(REG_SIZE, sz);
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cutoff_r = 42949673;
		min_r = 429497;
		mass_r = 42949673;
		dt_r = 2147484;
		size_r = 64'h1_0000_0000;
		held_px = 0; held_py = 0; held_vx = 0; held_vy = 0;
		acc_x = 0; acc_y = 0; sat_seen = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// held state before any first, all controls at once, zero distance
		queue_item(0, 0, 0, 0, 48'd10000000, 48'd5000000, 0, 1, 1);
		queue_item(48'h8000_0000, 48'h8000_0000, 0, 0, 48'h8010_0000, 48'h7FF0_0000, 1, 1, 1);
		queue_item(48'h4000_0000, 48'h4000_0000, 48'h1000_0000, 0,
			48'h4000_0000, 48'h4000_0000, 1, 1, 0);
		queue_item(0, 0, 0, 0, 48'h4000_0100, 48'h4000_0000, 0, 1, 1);
		queue_item(MAX48[W-1:0], MIN48[W-1:0], MAX48[W-1:0], MIN48[W-1:0],
			MIN48[W-1:0], MAX48[W-1:0], 1, 1, 1);
		queue_item(MIN48[W-1:0], MAX48[W-1:0], MIN48[W-1:0], MAX48[W-1:0],
			MAX48[W-1:0], MIN48[W-1:0], 1, 1, 1);
		queue_item(0, 0, 0, 0, 48'h100, 0, 1, 1, 0);
		queue_item('1, '1, '1, '1, '1, '1, 0, 0, 0);
		queue_item(0, 0, 0, 0, 0, 0, 0, 0, 1);
		queue_runs(180);
		drain();

		// wide cutoff, smallest nonzero mass, no motion, tiny domain
		set_regs(MAX48[W-1:0] * 2 + 1, 1, 1, 0, 1);
		write_reg(REG_SIZE + 3'd1, '1);
		queue_item(48'hFFFF_FFFF_FFFF, 0, MIN48[W-1:0], MIN48[W-1:0], 0, 0, 1, 0, 1);
		queue_item(48'h7, 48'h3, 48'h5, 48'h1, 48'h2, 48'h9, 1, 1, 1);
		queue_runs(200);
		drain();

		set_regs(48'h4_0000_0000, 48'h10_0000, 48'h1_0000_0000, 48'h1000_0000,
			48'h7FFF_FFFF_FFFF);
		queue_runs(200);
		drain();

		set_regs(1, '1, '1, '1, 48'h1_0000_0000);
		queue_runs(120);
		drain();

		set_regs(42949673, 0, 42949673, 2147484, 48'h1_0000_0000);
		queue_runs(100);
		drain();

		if (mismatches == 0)
			$display("PASS particle_force_accumulate_and_move");
		else
			$display("FAIL particle_force_accumulate_and_move");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		particle_item_t it;
		if (!arst_n) begin
			item_valid <= 1'b0;
			{particle_x, particle_y, particle_vx, particle_vy} <= '0;
			{neighbor_x, neighbor_y} <= '0;
			{first, has_neighbor, last} <= '0;
			tx_wait <= 0;
			calm_tx <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (tx_wait > 0) begin
				tx_wait <= tx_wait - 1;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				particle_x <= it.px;
				particle_y <= it.py;
				particle_vx <= it.pvx;
				particle_vy <= it.pvy;
				neighbor_x <= it.nx;
				neighbor_y <= it.ny;
				first <= it.f;
				has_neighbor <= it.h;
				last <= it.l;
				item_valid <= 1'b1;
				tx_wait <= calm_tx ? 0 : $urandom_range(0, 19);
				if ($urandom_range(0, 29) == 0) calm_tx <= !calm_tx;
			end else
				item_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		particle_item_t it;
		if (arst_n && item_valid && item_ready) begin
			it = '{particle_x, particle_y, particle_vx, particle_vy, neighbor_x, neighbor_y,
				first, has_neighbor, last};
			predict_move(it);
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			squeeze_left <= 0;
			squeeze_done <= 1'b0;
		end else if (!squeeze_done && moves_seen == 3) begin
			squeeze_left <= 5000;
			squeeze_done <= 1'b1;
		end else if (squeeze_left > 0)
			squeeze_left <= squeeze_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin : recv
		int nxt;
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_wait <= 0;
			calm_rx <= 1'b0;
		end else begin
			nxt = rx_wait;
			if (result_valid && result_ready) begin
				nxt = calm_rx ? 0 : $urandom_range(0, 19);
				if ($urandom_range(0, 19) == 0) calm_rx <= !calm_rx;
			end else if (nxt > 0)
				nxt--;
			rx_wait <= nxt;
			result_ready <= (nxt == 0) && (squeeze_left == 0);
		end
	end

	always @(posedge clk) begin
		moved_t e;
		if (arst_n && result_valid && result_ready) begin
			moves_seen++;
			if (expected_moves.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word x=%h y=%h", new_x, new_y);
			end else begin
				e = expected_moves.pop_front();
				if (new_x !== e.x || new_y !== e.y || new_vx !== e.vx || new_vy !== e.vy
						|| saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp x=%h y=%h vx=%h vy=%h sat=%b got %h %h %h %h %b",
							e.x, e.y, e.vx, e.vy, e.sat,
							new_x, new_y, new_vx, new_vy, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL particle_force_accumulate_and_move");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
